FILE: design/hsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_pkg: shared constants and helpers of the double heapsort
// Holds the store geometry, the RAM write data select codes and the
// double compare.
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int unsigned MaxElementsDef = 64;
  localparam int unsigned ValueW = 64;

  // RAM write data select
  localparam logic [1:0] WselIn = 2'd0;
  localparam logic [1:0] WselHeld = 2'd1;
  localparam logic [1:0] WselChild = 2'd2;
  localparam logic [1:0] WselRd = 2'd3;

  // Strict IEEE less-than on bit patterns; -0 equals +0, any NaN compares false.
  function automatic logic dbl_less(input logic [63:0] x, input logic [63:0] y);
    logic x_zero;
    logic y_zero;
    logic x_nan;
    logic y_nan;
    logic res;
    x_zero = (x[62:0] == 63'd0);
    y_zero = (y[62:0] == 63'd0);
    x_nan = (x[62:52] == 11'h7ff) && (x[51:0] != 52'd0);
    y_nan = (y[62:52] == 11'h7ff) && (y[51:0] != 52'd0);
    if (x_nan || y_nan) begin
      res = 1'b0;
    end else if (x_zero && y_zero) begin
      res = 1'b0;
    end else if (x[63] != y[63]) begin
      res = x[63];
    end else if (!x[63]) begin
      res = (x[62:0] < y[62:0]);
    end else begin
      res = (x[62:0] > y[62:0]);
    end
    return res;
  endfunction

endpackage : hsd_pkg
`default_nettype wire

FILE: design/hsd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module hsd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule : hsd_ram
`default_nettype wire

FILE: design/hsd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_datapath: element store and compare registers of the heapsort
// Holds the RAM, the sifted value, the larger-child register and the output
// register, all steered by controller commands.
// ----------------------------------------------------------------------------
module hsd_datapath
  import hsd_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDef,
  localparam int unsigned AddrW = (MaxElements > 1) ? $clog2(MaxElements) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  addr_i,
  input  wire logic [1:0]        wsel_i,   // 0 input, 1 held, 2 child, 3 read data
  input  wire logic [63:0]       in_value_i,
  input  wire logic              held_ld_i,
  input  wire logic              child_ld_i,
  input  wire logic              out_ld_i,
  output logic                   rd_gt_child_o,
  output logic                   held_lt_child_o,
  output logic [63:0]            out_value_o
);

  logic [63:0] rdata;
  logic [63:0] wdata;
  logic [63:0] held_q;
  logic [63:0] child_q;
  logic [63:0] out_q;

  always_comb begin
    case (wsel_i)
      WselIn:    wdata = in_value_i;
      WselHeld:  wdata = held_q;
      WselChild: wdata = child_q;
      default:   wdata = rdata;
    endcase
  end

  hsd_ram #(.Width(ValueW), .Depth(MaxElements)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .addr_i (addr_i),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (held_ld_i) begin
      held_q <= rdata;
    end
    if (child_ld_i) begin
      child_q <= rdata;
    end
    if (out_ld_i) begin
      out_q <= rdata;
    end
  end

  assign rd_gt_child_o = dbl_less(child_q, rdata);
  assign held_lt_child_o = dbl_less(held_q, child_q);
  assign out_value_o = out_q;

endmodule : hsd_datapath
`default_nettype wire

FILE: design/hsd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_ctrl: heapsort sequencer
// Loads the set, runs build and extraction phases through sift-down over the
// RAM port, then reads the sorted store out on the output stream.
// ----------------------------------------------------------------------------
module hsd_ctrl
  import hsd_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDef,
  localparam int unsigned AddrW = (MaxElements > 1) ? $clog2(MaxElements) : 1,
  localparam int unsigned CntW = $clog2(MaxElements + 1) + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_last_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output logic                  out_final_o,
  output logic                  out_ovf_o,
  input  wire logic             out_ready_i,
  output logic                  we_o,
  output logic [AddrW-1:0]      addr_o,
  output logic [1:0]            wsel_o,
  output logic                  held_ld_o,
  output logic                  child_ld_o,
  output logic                  out_ld_o,
  input  wire logic             rd_gt_child_i,
  input  wire logic             held_lt_child_i
);

  localparam logic [3:0] StLoad   = 4'd0;
  localparam logic [3:0] StOuter  = 4'd1;
  localparam logic [3:0] StHeldRd = 4'd2;  // child <= rdata (root read data)
  localparam logic [3:0] StEndWr  = 4'd3;  // store[end-1] <= root
  localparam logic [3:0] StSift   = 4'd4;  // issue read of child j
  localparam logic [3:0] StCj     = 4'd5;  // child j data, read j+1
  localparam logic [3:0] StCj1    = 4'd6;  // compare j+1 data
  localparam logic [3:0] StMove   = 4'd7;
  localparam logic [3:0] StPlace  = 4'd8;
  localparam logic [3:0] StOutRd  = 4'd9;
  localparam logic [3:0] StOutLd  = 4'd10;
  localparam logic [3:0] StOutHold = 4'd11;
  localparam logic [3:0] StBuildRd = 4'd12;
  localparam logic [3:0] StLastRd = 4'd13;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] bidx_q, bidx_d;
  logic [CntW-1:0] eidx_q, eidx_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic [CntW-1:0] k_q, k_d;
  logic            drop_q, drop_d;
  logic            ovf_q, ovf_d;
  logic            fin_q, fin_d;
  logic            ov_q, ov_d;

  localparam logic [CntW-1:0] Cap = CntW'(MaxElements);
  localparam logic [CntW-1:0] One = CntW'(1);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; bidx_d = bidx_q; eidx_d = eidx_q;
    i_d = i_q; j_d = j_q; k_d = k_q; drop_d = drop_q; ovf_d = ovf_q;
    fin_d = fin_q; ov_d = ov_q;
    we_o = 1'b0; addr_o = '0; wsel_o = WselIn;
    held_ld_o = 1'b0; child_ld_o = 1'b0; out_ld_o = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      StLoad: begin
        in_ready_o = 1'b1;
        addr_o = cnt_q[AddrW-1:0];
        if (in_valid_i) begin
          if (cnt_q < Cap) begin
            we_o = 1'b1;
            cnt_d = cnt_q + One;
          end else begin
            drop_d = 1'b1;
          end
          if (in_last_i) begin
            ovf_d = (cnt_q >= Cap) | drop_q;
            if (cnt_d >= CntW'(2)) begin
              bidx_d = (cnt_d >> 1) + One;
              eidx_d = cnt_d;
              state_d = StOuter;
            end else begin
              k_d = '0;
              state_d = StOutRd;
            end
          end
        end
      end
      StOuter: begin
        if (bidx_q > One) begin
          bidx_d = bidx_q - One;
          addr_o = AddrW'(bidx_q - CntW'(2));
          state_d = StBuildRd;
        end else begin
          addr_o = AddrW'(eidx_q - One);
          state_d = StLastRd;
        end
      end
      StBuildRd: begin
        held_ld_o = 1'b1;
        i_d = bidx_q;
        j_d = bidx_q << 1;
        state_d = StSift;
      end
      StLastRd: begin
        held_ld_o = 1'b1;
        addr_o = '0;
        state_d = StHeldRd;
      end
      StHeldRd: begin
        // read data now holds the root
        child_ld_o = 1'b1;
        state_d = StEndWr;
      end
      StEndWr: begin
        we_o = 1'b1;
        wsel_o = WselChild;
        addr_o = AddrW'(eidx_q - One);
        eidx_d = eidx_q - One;
        i_d = One;
        j_d = CntW'(2);
        if (eidx_q - One == One) begin
          state_d = StPlace;
        end else begin
          state_d = StSift;
        end
      end
      StSift: begin
        if (j_q <= eidx_q) begin
          addr_o = AddrW'(j_q - One);
          state_d = StCj;
        end else begin
          state_d = StPlace;
        end
      end
      StCj: begin
        child_ld_o = 1'b1;
        if (j_q < eidx_q) begin
          addr_o = AddrW'(j_q);
          state_d = StCj1;
        end else begin
          state_d = StMove;
        end
      end
      StCj1: begin
        if (rd_gt_child_i) begin
          child_ld_o = 1'b1;
          j_d = j_q + One;
        end
        state_d = StMove;
      end
      StMove: begin
        if (held_lt_child_i) begin
          we_o = 1'b1;
          wsel_o = WselChild;
          addr_o = AddrW'(i_q - One);
          i_d = j_q;
          j_d = j_q << 1;
          state_d = StSift;
        end else begin
          state_d = StPlace;
        end
      end
      StPlace: begin
        we_o = 1'b1;
        wsel_o = WselHeld;
        addr_o = AddrW'(i_q - One);
        if (bidx_q <= One && eidx_q == One) begin
          k_d = '0;
          state_d = StOutRd;
        end else begin
          state_d = StOuter;
        end
      end
      StOutRd: begin
        addr_o = k_q[AddrW-1:0];
        if (k_q >= cnt_q) begin
          cnt_d = '0; drop_d = 1'b0;
          state_d = StLoad;
        end else begin
          state_d = StOutLd;
        end
      end
      StOutLd: begin
        out_ld_o = 1'b1;
        wsel_o = WselRd;
        fin_d = (k_q + One == cnt_q);
        ov_d = ovf_q;
        k_d = k_q + One;
        state_d = StOutHold;
      end
      StOutHold: begin
        if (out_ready_i) begin
          state_d = StOutRd;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  assign out_valid_o = (state_q == StOutHold);
  assign out_final_o = fin_q;
  assign out_ovf_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad; cnt_q <= '0; bidx_q <= '0; eidx_q <= '0;
      i_q <= '0; j_q <= '0; k_q <= '0; drop_q <= 1'b0; ovf_q <= 1'b0;
      fin_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; bidx_q <= bidx_d; eidx_q <= eidx_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d; drop_q <= drop_d; ovf_q <= ovf_d;
      fin_q <= fin_d; ov_q <= ov_d;
    end
  end

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Cap)
    else $error("element count above capacity");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == StOutHold))
    else $error("output valid outside hold");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

endmodule : hsd_ctrl
`default_nettype wire

FILE: design/heap_sort_doubles.sv
`default_nettype none
// After the transfer flagged last, the set is sorted over the one RAM port; each result
// is then read from the store, loaded into the output register and held until taken.
// Throughput: one input item per cycle while loading; one set at a time.
// Reset: asynchronous, active low; clears count, drop flag and sequencer.
// The element RAM is not cleared; only entries of the current set are read.
// ----------------------------------------------------------------------------
// heap_sort_doubles: in-place heapsort of IEEE-754 double bit patterns
// Collects a set, sorts it ascending and streams it out with final flags.
// ----------------------------------------------------------------------------
module heap_sort_doubles
  import hsd_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] value
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [63:0] sorted_value
  output logic             m_axis_tlast,
  output logic             m_axis_tuser    // [0] overflow
);

  localparam int unsigned AddrW = (MaxElements > 1) ? $clog2(MaxElements) : 1;

  logic             we;
  logic [AddrW-1:0] addr;
  logic [1:0]       wsel;
  logic             held_ld;
  logic             child_ld;
  logic             out_ld;
  logic             rd_gt_child;
  logic             held_lt_child;

  hsd_ctrl #(.MaxElements(MaxElements)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_last_i      (s_axis_tlast),
    .in_ready_o     (s_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_final_o    (m_axis_tlast),
    .out_ovf_o      (m_axis_tuser),
    .out_ready_i    (m_axis_tready),
    .we_o           (we),
    .addr_o         (addr),
    .wsel_o         (wsel),
    .held_ld_o      (held_ld),
    .child_ld_o     (child_ld),
    .out_ld_o       (out_ld),
    .rd_gt_child_i  (rd_gt_child),
    .held_lt_child_i(held_lt_child)
  );

  hsd_datapath #(.MaxElements(MaxElements)) u_dp (
    .clk_i          (clk_i),
    .we_i           (we),
    .addr_i         (addr),
    .wsel_i         (wsel),
    .in_value_i     (s_axis_tdata),
    .held_ld_i      (held_ld),
    .child_ld_i     (child_ld),
    .out_ld_i       (out_ld),
    .rd_gt_child_o  (rd_gt_child),
    .held_lt_child_o(held_lt_child),
    .out_value_o    (m_axis_tdata)
  );

endmodule : heap_sort_doubles
`default_nettype wire
